// ----- rtl/first_fit_block_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_defines : assertion macros
// Shared property shorthands for the allocator's checkers.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, idle while reset is low
`define FFBA_AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffba: same-cycle check failed");

// next-cycle implication, idle while reset is low
`define FFBA_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffba: next-cycle check failed");

`endif

// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg : allocator types and constants
// Command and status codes, job record and engine states.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int SIZE_W = 17;
    localparam int ALOG_W = 4;
    localparam int ADDR_W = 16;
    localparam int USED_W = 17;
    localparam int STAT_W = 2;
    localparam int NEED_W = 18;   // size rounded up to an alignment of up to 32 KiB

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOFIT   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic              zero;
        logic [NEED_W-1:0] need;
        logic [ALOG_W-1:0] align_log2;
        logic [ADDR_W-1:0] addr;
    } t_job;

    typedef enum logic [3:0] {
        E_IDLE,
        E_ARD,
        E_AEV,
        E_AFIT,
        E_AGAP,
        E_APRV,
        E_AREM,
        E_ACUR,
        E_ADONE,
        E_FRD,
        E_FEV,
        E_FMG,
        E_FCLR
    } t_estate;

endpackage

`default_nettype wire

// ----- rtl/ffba_if.sv -----
// ----------------------------------------------------------------------------
// ffba_if : request and response channels
// Valid/ready channels carrying one request or one response per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffba_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [ffba_pkg::SIZE_W-1:0]   req_size;
    logic [ffba_pkg::ALOG_W-1:0]   align_log2;
    logic [ffba_pkg::ADDR_W-1:0]   block_addr;

    modport source (output valid, cmd, req_size, align_log2, block_addr, input ready);
    modport sink   (input valid, cmd, req_size, align_log2, block_addr, output ready);
endinterface

interface ffba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffba_pkg::STAT_W-1:0]   status;
    logic [ffba_pkg::ADDR_W-1:0]   addr_out;
    logic [ffba_pkg::USED_W-1:0]   used_bytes;

    modport source (output valid, status, addr_out, used_bytes, input ready);
    modport sink   (input valid, status, addr_out, used_bytes, output ready);
endinterface

`default_nettype wire

// ----- rtl/ffba_front.sv -----
// ----------------------------------------------------------------------------
// ffba_front : request intake
// Takes request beats, rounds the size to the alignment, flags zero size.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    ffba_req_if.sink            i_req,
    output ffba_pkg::t_job      o_job,
    output logic                o_job_valid,
    input  wire                 i_job_ready
);

    logic                              r_vld;
    ffba_pkg::t_job                    r_job;
    ffba_pkg::t_job                    n_job;
    logic [ffba_pkg::NEED_W-1:0]       mask;
    logic [ffba_pkg::NEED_W-1:0]       sum;

    assign i_req.ready = !r_vld || i_job_ready;

    always_comb begin
        mask             = (ffba_pkg::NEED_W'(1) << i_req.align_log2) - ffba_pkg::NEED_W'(1);
        sum              = ffba_pkg::NEED_W'(i_req.req_size) + mask;
        n_job.cmd        = ffba_pkg::t_cmd'(i_req.cmd);
        n_job.zero       = (i_req.req_size == '0);
        n_job.need       = sum & ~mask;
        n_job.align_log2 = i_req.align_log2;
        n_job.addr       = i_req.block_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_vld <= 1'b1;
        end else if (i_job_ready) begin
            r_vld <= 1'b0;
        end
        if (i_req.valid && i_req.ready) begin
            r_job <= n_job;
        end
    end

    assign o_job       = r_job;
    assign o_job_valid = r_vld;

endmodule

`default_nettype wire

// ----- rtl/ffba_queue.sv -----
// ----------------------------------------------------------------------------
// ffba_queue : two-entry job queue
// Decouples intake from the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ffba_pkg::t_job      i_job,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    output ffba_pkg::t_job      o_job,
    output logic                o_pop_valid,
    input  wire                 i_pop_ready
);

    ffba_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_job        = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ffba_engine.sv -----
// ----------------------------------------------------------------------------
// ffba_engine : descriptor table engine
// Walks and updates the descriptor table; one job at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_engine #(
    parameter int POOL_BYTES  = 65536,
    parameter int DESCRIPTORS = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ffba_pkg::t_job      i_job,
    input  wire                 i_job_valid,
    output logic                o_job_ready,
    ffba_rsp_if.source          o_rsp
);

    localparam int IW  = $clog2(DESCRIPTORS);
    localparam int KW  = $clog2(DESCRIPTORS + 1);
    localparam int SW  = $clog2(POOL_BYTES);
    localparam int LW  = $clog2(POOL_BYTES + 1);
    localparam int CW  = ((LW > ffba_pkg::NEED_W) ? LW : ffba_pkg::NEED_W) + 1;
    localparam logic [KW-1:0] NULL_LINK = KW'(DESCRIPTORS);
    localparam logic [LW-1:0] POOL_LEN  = LW'(POOL_BYTES);

    // table storage
    logic [SW-1:0] m_start [DESCRIPTORS];
    logic [LW-1:0] m_len   [DESCRIPTORS];
    logic [KW-1:0] m_link  [DESCRIPTORS];
    logic [DESCRIPTORS-1:0] r_vs, r_vl, r_vk;   // written since reset
    logic [DESCRIPTORS-1:0] r_use, r_free, n_use, n_free;

    // read port
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [SW-1:0] r_rd_start;
    logic [LW-1:0] r_rd_len;
    logic [KW-1:0] r_rd_link;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vs, r_rd_vl, r_rd_vk;
    logic [SW-1:0] e_start;
    logic [LW-1:0] e_len;
    logic [KW-1:0] e_link;

    // write ports
    logic          ws_en, wl_en, wk_en;
    logic [IW-1:0] ws_addr, wl_addr, wk_addr;
    logic [SW-1:0] ws_data;
    logic [LW-1:0] wl_data;
    logic [KW-1:0] wk_data;

    // control
    ffba_pkg::t_estate r_st, n_st;
    ffba_pkg::t_job    r_job, n_job;
    logic [KW-1:0] r_cur, n_cur, r_prev, n_prev, r_steps, n_steps, r_link, n_link;
    logic [KW-1:0] r_nx, n_nx;
    logic [SW-1:0] r_base, n_base;
    logic [LW-1:0] r_len, n_len, r_total, n_total;
    logic [CW-1:0] r_al, n_al, r_off, n_off;
    logic [IW-1:0] r_g, n_g, r_head, n_head;
    logic          r_out_valid, n_out_valid;
    ffba_pkg::t_status r_o_status, n_o_status;
    logic [ffba_pkg::ADDR_W-1:0] r_o_addr, n_o_addr;
    logic [ffba_pkg::USED_W-1:0] r_o_used, n_o_used;

    logic [CW-1:0] align_m, need_c, off_c;
    logic [KW-1:0] spare;
    logic          usable;

    function automatic logic [KW-1:0] first_spare(input logic [DESCRIPTORS-1:0] use_v);
        logic [KW-1:0] found;
        found = NULL_LINK;
        for (int k = DESCRIPTORS - 1; k >= 1; k--) begin
            if (!use_v[k]) found = KW'(k);
        end
        return found;
    endfunction

    // unwritten entries read as their reset value
    always_comb begin
        e_start = r_rd_vs ? r_rd_start : '0;
        e_len   = r_rd_vl ? r_rd_len : ((r_rd_idx == '0) ? POOL_LEN : '0);
        e_link  = r_rd_vk ? r_rd_link : NULL_LINK;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_start <= m_start[rd_addr];
            r_rd_len   <= m_len[rd_addr];
            r_rd_link  <= m_link[rd_addr];
            r_rd_idx   <= rd_addr;
        end
        if (ws_en) m_start[ws_addr] <= ws_data;
        if (wl_en) m_len[wl_addr]   <= wl_data;
        if (wk_en) m_link[wk_addr]  <= wk_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs    <= '0;
            r_vl    <= '0;
            r_vk    <= '0;
            r_rd_vs <= 1'b0;
            r_rd_vl <= 1'b0;
            r_rd_vk <= 1'b0;
        end else begin
            if (ws_en) r_vs[ws_addr] <= 1'b1;
            if (wl_en) r_vl[wl_addr] <= 1'b1;
            if (wk_en) r_vk[wk_addr] <= 1'b1;
            if (rd_en) begin
                r_rd_vs <= r_vs[rd_addr];
                r_rd_vl <= r_vl[rd_addr];
                r_rd_vk <= r_vk[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ffba_pkg::E_IDLE;
            r_use       <= DESCRIPTORS'(1);
            r_free      <= DESCRIPTORS'(1);
            r_head      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_use       <= n_use;
            r_free      <= n_free;
            r_head      <= n_head;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_job      <= n_job;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_steps    <= n_steps;
        r_link     <= n_link;
        r_nx       <= n_nx;
        r_base     <= n_base;
        r_len      <= n_len;
        r_al       <= n_al;
        r_off      <= n_off;
        r_g        <= n_g;
        r_o_status <= n_o_status;
        r_o_addr   <= n_o_addr;
        r_o_used   <= n_o_used;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.addr_out   = r_o_addr;
    assign o_rsp.used_bytes = r_o_used;

    always_comb begin
        n_st = r_st;   n_job = r_job;   n_cur = r_cur;   n_prev = r_prev;
        n_steps = r_steps;  n_link = r_link;  n_nx = r_nx;  n_base = r_base;
        n_len = r_len;  n_al = r_al;  n_off = r_off;  n_g = r_g;  n_head = r_head;
        n_total = r_total;  n_use = r_use;  n_free = r_free;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_o_status = r_o_status;  n_o_addr = r_o_addr;  n_o_used = r_o_used;
        o_job_ready = 1'b0;
        rd_en = 1'b0;  rd_addr = r_cur[IW-1:0];
        ws_en = 1'b0;  ws_addr = '0;  ws_data = '0;
        wl_en = 1'b0;  wl_addr = '0;  wl_data = '0;
        wk_en = 1'b0;  wk_addr = '0;  wk_data = '0;

        align_m = (CW'(1) << r_job.align_log2) - CW'(1);
        need_c  = CW'(r_job.need);
        off_c   = r_al - CW'(r_base);
        spare   = first_spare(r_use);
        usable  = 1'b0;

        unique case (r_st)
            ffba_pkg::E_IDLE: begin
                o_job_ready = !r_out_valid;
                if (i_job_valid && !r_out_valid) begin
                    n_job = i_job;
                    n_cur = '0;
                    if (i_job.cmd == ffba_pkg::CMD_FREE) begin
                        n_st = ffba_pkg::E_FRD;
                    end else if (i_job.zero) begin
                        n_out_valid = 1'b1;
                        n_o_status  = ffba_pkg::ST_ZERO;
                        n_o_addr    = '0;
                        n_o_used    = ffba_pkg::USED_W'(r_total);
                    end else begin
                        n_cur   = KW'(r_head);
                        n_prev  = NULL_LINK;
                        n_steps = '0;
                        n_st    = ffba_pkg::E_ARD;
                    end
                end
            end
            ffba_pkg::E_ARD: begin
                if (r_steps == NULL_LINK || r_cur >= NULL_LINK) begin
                    n_out_valid = 1'b1;
                    n_o_status  = ffba_pkg::ST_NOFIT;
                    n_o_addr    = '0;
                    n_o_used    = ffba_pkg::USED_W'(r_total);
                    n_st        = ffba_pkg::E_IDLE;
                end else begin
                    rd_en = 1'b1;
                    n_st  = ffba_pkg::E_AEV;
                end
            end
            ffba_pkg::E_AEV: begin
                n_base = e_start;
                n_len  = e_len;
                n_link = e_link;
                n_al   = (CW'(e_start) + align_m) & ~align_m;
                if (r_free[r_rd_idx] && CW'(e_len) >= need_c) begin
                    n_st = ffba_pkg::E_AFIT;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = e_link;
                    n_steps = r_steps + KW'(1);
                    n_st    = ffba_pkg::E_ARD;
                end
            end
            ffba_pkg::E_AFIT: begin
                usable = (CW'(r_len) >= off_c + need_c) &&
                         ((off_c == '0) || (spare != NULL_LINK));
                if (usable) begin
                    n_off = off_c;
                    n_g   = spare[IW-1:0];
                    n_free[r_cur[IW-1:0]] = 1'b0;
                    n_st  = (off_c != '0) ? ffba_pkg::E_AGAP : ffba_pkg::E_AREM;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = r_link;
                    n_steps = r_steps + KW'(1);
                    n_st    = ffba_pkg::E_ARD;
                end
            end
            ffba_pkg::E_AGAP: begin
                // gap in front of the aligned start becomes its own free block
                ws_en = 1'b1;  ws_addr = r_g;  ws_data = r_base;
                wl_en = 1'b1;  wl_addr = r_g;  wl_data = LW'(r_off);
                wk_en = 1'b1;  wk_addr = r_g;  wk_data = r_cur;
                n_use[r_g]  = 1'b1;
                n_free[r_g] = 1'b1;
                n_st = ffba_pkg::E_APRV;
            end
            ffba_pkg::E_APRV: begin
                if (r_prev != NULL_LINK) begin
                    wk_en = 1'b1;  wk_addr = r_prev[IW-1:0];  wk_data = KW'(r_g);
                end else begin
                    n_head = r_g;
                end
                ws_en = 1'b1;  ws_addr = r_cur[IW-1:0];  ws_data = SW'(r_al);
                wl_en = 1'b1;  wl_addr = r_cur[IW-1:0];  wl_data = r_len - LW'(r_off);
                n_len = r_len - LW'(r_off);
                n_st  = ffba_pkg::E_AREM;
            end
            ffba_pkg::E_AREM: begin
                if (CW'(r_len) > need_c && spare != NULL_LINK) begin
                    ws_en = 1'b1;  ws_addr = spare[IW-1:0];  ws_data = SW'(r_al + need_c);
                    wl_en = 1'b1;  wl_addr = spare[IW-1:0];
                    wl_data = r_len - LW'(r_job.need);
                    wk_en = 1'b1;  wk_addr = spare[IW-1:0];  wk_data = r_link;
                    n_use[spare[IW-1:0]]  = 1'b1;
                    n_free[spare[IW-1:0]] = 1'b1;
                    n_g  = spare[IW-1:0];
                    n_st = ffba_pkg::E_ACUR;
                end else begin
                    n_st = ffba_pkg::E_ADONE;
                end
            end
            ffba_pkg::E_ACUR: begin
                wk_en = 1'b1;  wk_addr = r_cur[IW-1:0];  wk_data = KW'(r_g);
                wl_en = 1'b1;  wl_addr = r_cur[IW-1:0];  wl_data = LW'(r_job.need);
                n_len = LW'(r_job.need);
                n_st  = ffba_pkg::E_ADONE;
            end
            ffba_pkg::E_ADONE: begin
                n_total     = r_total + r_len;
                n_out_valid = 1'b1;
                n_o_status  = ffba_pkg::ST_OK;
                n_o_addr    = ffba_pkg::ADDR_W'(r_al);
                n_o_used    = ffba_pkg::USED_W'(n_total);
                n_st        = ffba_pkg::E_IDLE;
            end
            ffba_pkg::E_FRD: begin
                if (r_cur == NULL_LINK) begin
                    n_out_valid = 1'b1;
                    n_o_status  = ffba_pkg::ST_UNKNOWN;
                    n_o_addr    = '0;
                    n_o_used    = ffba_pkg::USED_W'(r_total);
                    n_st        = ffba_pkg::E_IDLE;
                end else begin
                    rd_en = 1'b1;
                    n_st  = ffba_pkg::E_FEV;
                end
            end
            ffba_pkg::E_FEV: begin
                if (r_use[r_rd_idx] && !r_free[r_rd_idx] &&
                    CW'(e_start) == CW'(r_job.addr)) begin
                    n_free[r_rd_idx] = 1'b1;
                    n_total = (r_total >= e_len) ? (r_total - e_len) : '0;
                    n_base  = e_start;
                    n_len   = e_len;
                    n_nx    = e_link;
                    if (e_link < NULL_LINK && e_link != r_cur &&
                        r_use[e_link[IW-1:0]] && r_free[e_link[IW-1:0]]) begin
                        rd_en   = 1'b1;
                        rd_addr = e_link[IW-1:0];
                        n_st    = ffba_pkg::E_FMG;
                    end else begin
                        n_out_valid = 1'b1;
                        n_o_status  = ffba_pkg::ST_OK;
                        n_o_addr    = '0;
                        n_o_used    = ffba_pkg::USED_W'(n_total);
                        n_st        = ffba_pkg::E_IDLE;
                    end
                end else begin
                    n_cur = r_cur + KW'(1);
                    n_st  = ffba_pkg::E_FRD;
                end
            end
            ffba_pkg::E_FMG: begin
                if (CW'(r_base) + CW'(r_len) == CW'(e_start)) begin
                    wl_en = 1'b1;  wl_addr = r_cur[IW-1:0];  wl_data = r_len + e_len;
                    wk_en = 1'b1;  wk_addr = r_cur[IW-1:0];  wk_data = e_link;
                    n_use[r_nx[IW-1:0]]  = 1'b0;
                    n_free[r_nx[IW-1:0]] = 1'b0;
                    n_st = ffba_pkg::E_FCLR;
                end else begin
                    n_out_valid = 1'b1;
                    n_o_status  = ffba_pkg::ST_OK;
                    n_o_addr    = '0;
                    n_o_used    = ffba_pkg::USED_W'(r_total);
                    n_st        = ffba_pkg::E_IDLE;
                end
            end
            ffba_pkg::E_FCLR: begin
                // merged descriptor goes back to its cleared form
                ws_en = 1'b1;  ws_addr = r_nx[IW-1:0];  ws_data = '0;
                wl_en = 1'b1;  wl_addr = r_nx[IW-1:0];  wl_data = '0;
                wk_en = 1'b1;  wk_addr = r_nx[IW-1:0];  wk_data = NULL_LINK;
                n_out_valid = 1'b1;
                n_o_status  = ffba_pkg::ST_OK;
                n_o_addr    = '0;
                n_o_used    = ffba_pkg::USED_W'(r_total);
                n_st        = ffba_pkg::E_IDLE;
            end
            default: n_st = ffba_pkg::E_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator : first-fit pool allocator
// Allocate and free requests over a pool managed by a linked descriptor table.
// ----------------------------------------------------------------------------
//  channel  | dir | beat carries
//  ---------+-----+------------------------------------------------------
//  i_req    | in  | cmd, req_size, align_log2, block_addr
//  o_rsp    | out | status, addr_out, used_bytes
//
//  An allocate takes a table read and a fit check per descriptor walked,
//  plus an alignment check when a block fits by size, then a table update;
//  a free takes a table read and a match check per descriptor scanned,
//  then may merge with the next block. The single-port table read in the
//  engine sets the pace. Sync reset restores the table at once (no
//  clearing pass).
//  Intake and a two-entry queue keep taking requests while the engine works
//  or a response waits, until both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
    parameter int POOL_BYTES  = 65536,
    parameter int DESCRIPTORS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ffba_req_if.sink    i_req,
    ffba_rsp_if.source  o_rsp
);

    ffba_pkg::t_job front_job;
    logic           front_valid;
    logic           front_ready;
    ffba_pkg::t_job q_job;
    logic           q_valid;
    logic           q_ready;

    // intake: size rounding and zero-size flag
    ffba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    // short queue between intake and engine
    ffba_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (front_job),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .o_job        (q_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready)
    );

    // table walk, split, merge and the response register
    ffba_engine #(
        .POOL_BYTES  (POOL_BYTES),
        .DESCRIPTORS (DESCRIPTORS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/ffba_checker.sv -----
// ----------------------------------------------------------------------------
// ffba_checker : response port checks
// Watches the response channel of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_block_allocator_defines.svh"

module ffba_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_valid,
    input wire                          i_ready,
    input wire [ffba_pkg::STAT_W-1:0]   i_status,
    input wire [ffba_pkg::ADDR_W-1:0]   i_addr,
    input wire [ffba_pkg::USED_W-1:0]   i_used
);

    // responses with any status other than OK report a zero offset
    `FFBA_AST_IMPLY(a_addr_zero, i_clk, i_rst_n, i_valid && i_status != ffba_pkg::ST_OK, i_addr == '0)

    // no response right after reset
    `FFBA_AST_IMPLY(a_rst_quiet, i_clk, i_rst_n, $past(!i_rst_n), !i_valid)

    // a stalled response holds
    `FFBA_AST_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_status) && $stable(i_addr) && $stable(i_used))

endmodule

bind first_fit_block_allocator ffba_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_status (o_rsp.status),
    .i_addr   (o_rsp.addr_out),
    .i_used   (o_rsp.used_bytes)
);

`default_nettype wire
